FILE: src/pog_pkg.sv
// Shared types and constants for the pump overcurrent guard.
// No dependencies; imported by the top level and its checker.
package pog_pkg;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LEVEL  = 3'd1,
    OP_MODE   = 3'd2,
    OP_SWITCH = 3'd3,
    OP_DEV    = 3'd4
  } pog_op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_BAD_KIND = 2'd2
  } pog_status_e;

  // Pump device states
  typedef enum logic [1:0] {
    DEV_SHUTDOWN = 2'd0,
    DEV_WORK     = 2'd1,
    DEV_CLOSING  = 2'd2,
    DEV_ERROR    = 2'd3
  } pog_dev_e;

  // Preset modes
  typedef enum logic [2:0] {
    MODE_OFF  = 3'd0,
    MODE_LOW  = 3'd1,
    MODE_MID  = 3'd2,
    MODE_HIGH = 3'd3,
    MODE_MAX  = 3'd4
  } pog_mode_e;

  // Switch kinds
  typedef enum logic [1:0] {
    SW_ON      = 2'd0,
    SW_OFF     = 2'd1,
    SW_TOGGLE  = 2'd2,
    SW_INVALID = 2'd3
  } pog_switch_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_PWM_MAX  = 2'd0,
    REG_OC_THR   = 2'd1,
    REG_OC_SET   = 2'd2,
    REG_OC_CLEAR = 2'd3
  } pog_reg_e;

  localparam int unsigned DutyW  = 12;
  localparam int unsigned CurW   = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // Register reset values
  localparam logic [DutyW-1:0]  PwmMaxRst  = 12'd1000;
  localparam logic [CurW-1:0]   OcThrRst   = 16'd2000;
  localparam logic [CountW-1:0] OcSetRst   = 4'd3;
  localparam logic [CountW-1:0] OcClearRst = 4'd5;

  // Preset duty values
  localparam logic [CurW-1:0] PresetLow  = 16'd300;
  localparam logic [CurW-1:0] PresetMid  = 16'd600;
  localparam logic [CurW-1:0] PresetHigh = 16'd800;

  // One result item
  typedef struct packed {
    logic [1:0]       status;
    logic [DutyW-1:0] duty;
    logic [1:0]       dev_state;
    logic [2:0]       mode;
    logic             protect;
  } pog_result_t;

endpackage

FILE: src/pump_overcurrent_guard_top.sv
// Top level of the pump overcurrent guard: request decode, state update,
// result buffering and the APB register file. Depends on pog_pkg.
//
// Each accepted request is decoded combinationally against the current pump
// state; the state registers and the result (in the output register, or in
// the spare slot while the output is stalled) update at the same edge. A new
// request can be taken every cycle while in_stall_o is low. Results pass
// through a two-entry buffer (output register plus one spare slot): in_stall_o
// rises only when the spare slot is occupied, i.e. when the consumer has held
// out_stall_i while two results were pending. Registers are written over APB
// with no wait states and read back at byte addresses 0, 4, 8 and 12.
module pump_overcurrent_guard_top
  import pog_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        opcode_i,
  input  logic [15:0]       level_i,
  input  logic [2:0]        mode_sel_i,
  input  logic [1:0]        switch_kind_i,
  input  logic              force_req_i,
  input  logic [1:0]        target_state_i,
  input  logic [15:0]       current_ma_i,
  input  logic              sys_active_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [11:0]       pwm_duty_o,
  output logic [1:0]        dev_state_o,
  output logic [2:0]        mode_now_o,
  output logic              protect_o,
  // configuration
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [DataW-1:0]  pwdata_i,
  output logic [DataW-1:0]  prdata_o,
  output logic              pready_o
);

  // Configuration registers
  logic [DutyW-1:0]  pwm_max_q;
  logic [CurW-1:0]   oc_thr_q;
  logic [CountW-1:0] oc_set_q;
  logic [CountW-1:0] oc_clear_q;
  logic              cfg_wr;

  // Pump state
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [1:0]        pstate_q, pstate_d;
  logic [2:0]        pmode_q, pmode_d;
  logic              prot_q, prot_d;
  logic [CountW-1:0] over_q, over_d;
  logic [CountW-1:0] norm_q, norm_d;
  logic [1:0]        status_d;

  // Result buffer
  logic              out_valid_q, skid_valid_q;
  pog_result_t       out_q, skid_q, res_d;
  logic              accept, out_free;

  // Working values for the decode
  logic              over_cur;
  logic [CurW-1:0]   lvl_req;
  logic              lvl_en;
  logic [1:0]        dev_req;
  logic              dev_en;
  logic [1:0]        want;
  logic              shut_en;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_max_q  <= PwmMaxRst;
      oc_thr_q   <= OcThrRst;
      oc_set_q   <= OcSetRst;
      oc_clear_q <= OcClearRst;
    end else if (cfg_wr) begin
      case (paddr_i[3:2])
        REG_PWM_MAX:  pwm_max_q  <= pwdata_i[DutyW-1:0];
        REG_OC_THR:   oc_thr_q   <= pwdata_i[CurW-1:0];
        REG_OC_SET:   oc_set_q   <= pwdata_i[CountW-1:0];
        REG_OC_CLEAR: oc_clear_q <= pwdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr_i[3:2])
      REG_PWM_MAX:  prdata_o = {{(DataW-DutyW){1'b0}}, pwm_max_q};
      REG_OC_THR:   prdata_o = {{(DataW-CurW){1'b0}}, oc_thr_q};
      REG_OC_SET:   prdata_o = {{(DataW-CountW){1'b0}}, oc_set_q};
      REG_OC_CLEAR: prdata_o = {{(DataW-CountW){1'b0}}, oc_clear_q};
      default:      prdata_o = '0;
    endcase
  end

  assign over_cur = current_ma_i > oc_thr_q;

  // Decode the request: pick the level or device-state change it asks for
  always_comb begin
    lvl_req = '0;
    lvl_en  = 1'b0;
    dev_req = DEV_SHUTDOWN;
    dev_en  = 1'b0;
    want    = DEV_SHUTDOWN;
    pmode_d = pmode_q;
    case (switch_kind_i)
      SW_ON:     want = DEV_WORK;
      SW_OFF:    want = DEV_SHUTDOWN;
      SW_TOGGLE: want = (pstate_q == DEV_WORK) ? DEV_SHUTDOWN : DEV_WORK;
      default:   want = DEV_SHUTDOWN;
    endcase
    case (opcode_i)
      OP_LEVEL: begin
        lvl_req = level_i;
        lvl_en  = 1'b1;
      end
      OP_MODE: begin
        lvl_en = 1'b1;
        case (mode_sel_i)
          MODE_LOW:  lvl_req = PresetLow;
          MODE_MID:  lvl_req = PresetMid;
          MODE_HIGH: lvl_req = PresetHigh;
          MODE_MAX:  lvl_req = {{(CurW-DutyW){1'b0}}, pwm_max_q};
          default:   lvl_req = '0;
        endcase
        // unknown modes fall back to off
        pmode_d = (mode_sel_i > MODE_MAX) ? MODE_OFF : mode_sel_i;
      end
      OP_SWITCH: begin
        dev_req = want;
        dev_en  = (switch_kind_i != SW_INVALID) &&
                  !((pstate_q == want) && !force_req_i);
      end
      OP_DEV: begin
        dev_req = target_state_i;
        dev_en  = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    duty_d   = duty_q;
    pstate_d = pstate_q;
    prot_d   = prot_q;
    over_d   = over_q;
    norm_d   = norm_q;
    status_d = ST_OK;
    shut_en  = 1'b0;

    if (opcode_i == OP_TICK) begin
      // count consecutive overcurrent / normal samples
      if (!sys_active_i) begin
        over_d = '0;
        norm_d = '0;
        prot_d = 1'b0;
      end else if (over_cur) begin
        norm_d = '0;
        if (!prot_q) begin
          over_d = CountW'(over_q + 1'b1);
          if (over_d >= oc_set_q) begin
            over_d = '0;
            prot_d = 1'b1;
          end
        end
      end else begin
        over_d = '0;
        if (prot_q) begin
          norm_d = CountW'(norm_q + 1'b1);
          if (norm_d >= oc_clear_q) begin
            norm_d = '0;
            prot_d = 1'b0;
          end
        end
      end
      shut_en = !(sys_active_i && (pstate_q == DEV_WORK) && !prot_d);
    end else if (lvl_en) begin
      // refuse an increase under protection or high current
      if ((lvl_req > {{(CurW-DutyW){1'b0}}, duty_q}) && (prot_q || over_cur)) begin
        status_d = ST_REFUSED;
      end else begin
        duty_d = (lvl_req > {{(CurW-DutyW){1'b0}}, pwm_max_q}) ? pwm_max_q
                                                              : lvl_req[DutyW-1:0];
        pstate_d = (duty_d != '0) ? DEV_WORK : DEV_SHUTDOWN;
      end
    end else if (opcode_i == OP_SWITCH && switch_kind_i == SW_INVALID) begin
      status_d = ST_BAD_KIND;
    end else if (dev_en) begin
      pstate_d = dev_req;
      shut_en  = (dev_req == DEV_CLOSING) || (dev_req == DEV_SHUTDOWN);
    end

    // shut the output down only when it is running
    if (shut_en && (duty_q != '0)) begin
      duty_d   = '0;
      pstate_d = DEV_SHUTDOWN;
    end
  end

  assign res_d.status    = status_d;
  assign res_d.duty      = duty_d;
  assign res_d.dev_state = pstate_d;
  assign res_d.mode      = (shut_en && (duty_q != '0)) ? MODE_OFF : pmode_d;
  assign res_d.protect   = prot_d;

  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = skid_valid_q;

  // State update on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= '0;
      pstate_q <= DEV_SHUTDOWN;
      pmode_q  <= MODE_OFF;
      prot_q   <= 1'b0;
      over_q   <= '0;
      norm_q   <= '0;
    end else if (accept) begin
      duty_q   <= duty_d;
      pstate_q <= pstate_d;
      pmode_q  <= res_d.mode;
      prot_q   <= prot_d;
      over_q   <= over_d;
      norm_q   <= norm_d;
    end
  end

  // Result buffer: output register with one spare slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end
    if (!out_free && accept) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign pwm_duty_o  = out_q.duty;
  assign dev_state_o = out_q.dev_state;
  assign mode_now_o  = out_q.mode;
  assign protect_o   = out_q.protect;

endmodule

FILE: src/pog_checker.sv
// Port-level checks for the pump overcurrent guard, bound to the top level.
// Depends on pog_pkg and pump_overcurrent_guard_top.
module pog_checker
  import pog_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       status_o,
  input logic [11:0]      pwm_duty_o,
  input logic [1:0]       dev_state_o,
  input logic [2:0]       mode_now_o,
  input logic             protect_o,
  input logic             psel_i,
  input logic             penable_i,
  input logic             pwrite_i,
  input logic [AddrW-1:0] paddr_i,
  input logic [DataW-1:0] pwdata_i,
  input logic [DataW-1:0] prdata_o
);

  // Latched protection always leaves the pump at zero duty
  a_prot_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && protect_o |-> pwm_duty_o == '0)
    else $error("duty nonzero while protection latched");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(pwm_duty_o) && $stable(dev_state_o) && $stable(mode_now_o) &&
      $stable(protect_o))
    else $error("stalled result changed");

  // Requests are only stalled while a result is pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty output");

  // Threshold written over APB reads back on the next cycle
  a_thr_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i && (paddr_i[3:2] == REG_OC_THR) |=>
      (!(paddr_i[3:2] == REG_OC_THR) || (prdata_o[15:0] == $past(pwdata_i[15:0]))))
    else $error("threshold readback mismatch");

endmodule

bind pump_overcurrent_guard_top pog_checker u_pog_checker (.*);
